FILE: rtl/core/fqoc_pkg.sv
// Shared types and constants for the FIFO queue with order check.
// Holds the request and status codes, the controller states and the result word.
// Depends on nothing.
package fqoc_pkg;

    // Default number of slots in the ring.
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths of the channel words.
    localparam int VALUE_W = 32;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    // Request codes carried by an input word.
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_STATUS = 2'd3
    } action_t;

    // Status codes reported in a result word.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // One result word as it travels from the controller to the output register.
    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_empty;
        logic                      is_ascending;
    } result_t;

endpackage

FILE: rtl/core/fifo_queue_with_order_check.sv
// FIFO queue of signed 32-bit words with a running order check. Each input word
// is a push, pop, clear or status request and yields exactly one result word.
// A request runs as a synchronous read of the head slot pair from the slot memory,
// followed by the update of the pointers and counts and the write back; a new
// word is taken only once the last one has been committed. The output register
// frees the input side while a result waits; a word taken meanwhile waits in the
// controller until that register is free. No clearing pass is needed after reset.
// Depends on fqoc_pkg, fqoc_mem and fqoc_ctrl.
module fifo_queue_with_order_check
    import fqoc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ACT_W-1:0]          s_action,
    input  logic signed [VALUE_W-1:0] s_push_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_pop_value,
    output logic [STAT_W-1:0]         m_status,
    output logic [OCC_W-1:0]          m_occupancy,
    output logic                      m_is_empty,
    output logic                      m_is_ascending
);

    localparam int AW = $clog2(DEPTH);

    logic                      res_ready;
    logic                      res_valid;
    result_t                   res;
    result_t                   res_reg;
    logic                      m_valid_reg, m_valid_next;
    logic                      mem_wr_en;
    logic [AW-1:0]             mem_wr_addr;
    logic signed [VALUE_W-1:0] mem_wr_data;
    logic                      mem_rd_en;
    logic [AW-1:0]             mem_rd_addr_a;
    logic [AW-1:0]             mem_rd_addr_b;
    logic signed [VALUE_W-1:0] mem_rd_data_a;
    logic signed [VALUE_W-1:0] mem_rd_data_b;

    fqoc_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_valid),
        .req_ready     (s_ready),
        .req_action    (s_action),
        .req_value     (s_push_value),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .res           (res),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_a (mem_rd_data_a),
        .mem_rd_data_b (mem_rd_data_b)
    );

    fqoc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (mem_rd_en),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

    // The output register can take a result when empty or being emptied.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pop_value    = res_reg.pop_value;
    assign m_status       = res_reg.status;
    assign m_occupancy    = res_reg.occupancy;
    assign m_is_empty     = res_reg.is_empty;
    assign m_is_ascending = res_reg.is_ascending;

    // Only one word is in flight, so acceptance is never followed by acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input word accepted while another is in progress");

    // A failed request never returns a popped word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> (m_pop_value == '0))
        else $error("failed request carries a popped word");

    // An empty queue always counts as ordered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> m_is_ascending)
        else $error("empty queue reported out of order");

    // A result is only loaded into a register that is free or being emptied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !res_valid)
        else $error("result overwrote an untaken word");

endmodule

FILE: rtl/core/fqoc_mem.sv
// Slot memory of the queue: one write port and two registered read ports.
// Read data is registered and appears in the cycle after the read enable.
// Depends on fqoc_pkg for the value width.
module fqoc_mem
    import fqoc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr_a,
    input  logic [AW-1:0]             rd_addr_b,
    output logic signed [VALUE_W-1:0] rd_data_a,
    output logic signed [VALUE_W-1:0] rd_data_b
);

    logic signed [VALUE_W-1:0] slots_reg [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_a_reg;
    logic signed [VALUE_W-1:0] rd_data_b_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots_reg[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= slots_reg[rd_addr_a];
            rd_data_b_reg <= slots_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: rtl/core/fqoc_ctrl.sv
// Queue controller: head, tail, count and descent bookkeeping around the slot memory.
// Reads the head pair on acceptance and commits the update in the execute state once the result side is ready.
// Depends on fqoc_pkg for codes, states and the result word.
module fqoc_ctrl
    import fqoc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Request side.
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [ACT_W-1:0]          req_action,
    input  logic signed [VALUE_W-1:0] req_value,
    // Result side.
    input  logic                      res_ready,
    output logic                      res_valid,
    output result_t                   res,
    // Memory side.
    output logic                      mem_wr_en,
    output logic [AW-1:0]             mem_wr_addr,
    output logic signed [VALUE_W-1:0] mem_wr_data,
    output logic                      mem_rd_en,
    output logic [AW-1:0]             mem_rd_addr_a,
    output logic [AW-1:0]             mem_rd_addr_b,
    input  logic signed [VALUE_W-1:0] mem_rd_data_a,
    input  logic signed [VALUE_W-1:0] mem_rd_data_b
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = $clog2(DEPTH);

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [DW-1:0]             desc_reg, desc_next;
    logic signed [VALUE_W-1:0] newest_reg, newest_next;
    action_t                   act_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      accept;
    logic                      commit;
    logic signed [VALUE_W-1:0] pop_value;
    status_t                   status;

    // Ring index advance with wrap at the last slot.
    function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
        next_index = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign accept = req_valid && req_ready;
    assign commit = (state_reg == ST_EXEC) && res_ready;

    // Head pair is read as the word is taken in.
    assign mem_rd_en     = accept;
    assign mem_rd_addr_a = head_reg;
    assign mem_rd_addr_b = next_index(head_reg);

    // Request word capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= action_t'(req_action);
            value_reg <= req_value;
        end
    end

    // State machine register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (res_ready) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Queue update for the word held in the execute state.
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        desc_next   = desc_reg;
        newest_next = newest_reg;
        pop_value   = '0;
        status      = STAT_OK;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_reg;
        mem_wr_data = value_reg;
        unique case (act_reg)
            ACT_PUSH: begin
                if (count_reg == CW'(DEPTH)) begin
                    status = STAT_FULL;
                end else begin
                    if ((count_reg != '0) && (value_reg < newest_reg)) begin
                        desc_next = desc_reg + 1'b1;
                    end
                    mem_wr_en   = commit;
                    tail_next   = next_index(tail_reg);
                    newest_next = value_reg;
                    count_next  = count_reg + 1'b1;
                end
            end
            ACT_POP: begin
                if (count_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    pop_value = mem_rd_data_a;
                    if ((count_reg > CW'(1)) && (mem_rd_data_b < mem_rd_data_a)
                            && (desc_reg != '0)) begin
                        desc_next = desc_reg - 1'b1;
                    end
                    head_next  = next_index(head_reg);
                    count_next = count_reg - 1'b1;
                    // The last word leaving empties the descent count too.
                    if (count_reg == CW'(1)) begin
                        desc_next = '0;
                    end
                end
            end
            ACT_CLEAR: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                desc_next  = '0;
            end
            ACT_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    // Result word.
    always_comb begin
        res.pop_value    = pop_value;
        res.status       = status;
        res.occupancy    = OCC_W'(count_next);
        res.is_empty     = (count_next == '0);
        res.is_ascending = (desc_next == '0);
    end

    // Queue bookkeeping registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            desc_reg  <= '0;
        end else if (commit) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            desc_reg  <= desc_next;
        end
    end

    // Newest word, only read while the queue holds something.
    always_ff @(posedge aclk) begin
        if (commit) begin
            newest_reg <= newest_next;
        end
    end

endmodule

FILE: tb/fifo_queue_with_order_check_tb.sv
`timescale 1ns / 100ps
// Testbench for the FIFO queue with order check: directed and random requests with
// a predictor run on accepted words, random idling on both channels and a long output hold-off.
// Depends on fqoc_pkg and the fifo_queue_with_order_check RTL.
module fifo_queue_with_order_check_tb
    import fqoc_pkg::*;
();

    localparam int QDEPTH         = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 200;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [ACT_W-1:0]          s_action       = ACT_STATUS;
    logic signed [VALUE_W-1:0] s_push_value   = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [VALUE_W-1:0] m_pop_value;
    logic [STAT_W-1:0]         m_status;
    logic [OCC_W-1:0]          m_occupancy;
    logic                      m_is_empty;
    logic                      m_is_ascending;

    // Shadow of the queue as the predictor sees it.
    logic signed [VALUE_W-1:0] ring [QDEPTH];
    int                        rd_ptr;
    int                        wr_ptr;
    int                        held;
    int                        descents;
    logic signed [VALUE_W-1:0] last_pushed;

    // Reports still owed by the block, oldest first.
    result_t reports_due [$];

    int error_count  = 0;
    int stall_cycles = 0;
    bit idle_en      = 1'b1;
    int hold_len     = 0;
    bit hold_go      = 1'b0;
    bit hold_seen    = 1'b0;
    int hold_left    = 0;

    fifo_queue_with_order_check #(
        .DEPTH(QDEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy),
        .m_is_empty    (m_is_empty),
        .m_is_ascending(m_is_ascending)
    );

    always #1 aclk = ~aclk;

    // Applies one request to the shadow queue and returns the report it should give.
    function automatic result_t queue_report_after(input action_t act,
                                                   input logic signed [VALUE_W-1:0] val);
        result_t rep;
        int      nxt;
        rep = '0;
        rep.status = STAT_OK;
        case (act)
            ACT_PUSH: begin
                if (held >= QDEPTH) begin
                    rep.status = STAT_FULL;
                end else begin
                    if (held > 0 && val < last_pushed) descents++;
                    ring[wr_ptr] = val;
                    wr_ptr = (wr_ptr + 1) % QDEPTH;
                    last_pushed = val;
                    held++;
                end
            end
            ACT_POP: begin
                if (held == 0) begin
                    rep.status = STAT_EMPTY;
                end else begin
                    nxt = (rd_ptr + 1) % QDEPTH;
                    rep.pop_value = ring[rd_ptr];
                    // Removing the head drops a descent if the next word is smaller.
                    if (held >= 2 && ring[nxt] < ring[rd_ptr] && descents > 0) descents--;
                    rd_ptr = nxt;
                    held--;
                    if (held == 0) descents = 0;
                end
            end
            ACT_CLEAR: begin
                rd_ptr   = 0;
                wr_ptr   = 0;
                held     = 0;
                descents = 0;
            end
            default: ;
        endcase
        rep.occupancy    = OCC_W'(held);
        rep.is_empty     = (held == 0);
        rep.is_ascending = (descents == 0);
        return rep;
    endfunction

    // Predicts on every accepted input word and checks every accepted result word.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("result word arrived with none expected");
                    error_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, got %0d", want.pop_value, m_pop_value);
                        error_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        error_count++;
                    end
                    if (m_occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, m_occupancy);
                        error_count++;
                    end
                    if (m_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, m_is_empty);
                        error_count++;
                    end
                    if (m_is_ascending !== want.is_ascending) begin
                        $error("is_ascending: expected %0d, got %0d",
                               want.is_ascending, m_is_ascending);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                reports_due.push_back(queue_report_after(action_t'(s_action), s_push_value));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_en && $urandom_range(99) < 14);
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial begin
        wait (aresetn);
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one word and returns once it has been accepted; valid is left high.
    task automatic send_word(input action_t act, input logic signed [VALUE_W-1:0] val);
        while (idle_en && $urandom_range(99) < 14) begin
            s_valid      <= 1'b0;
            s_action     <= ACT_W'($urandom_range(3));
            s_push_value <= $urandom;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_push_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Withdraws the input and waits until every owed report has arrived.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    // Value mix: extremes, a narrow band that gives ties and descents, and full range.
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3, 4, 5: return VALUE_W'($urandom_range(20)) - 32'sd10;
            default: return $urandom;
        endcase
    endfunction

    function automatic action_t pick_action(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 2) return ACT_CLEAR;
        if (r < 10) return ACT_STATUS;
        if ($urandom_range(99) < push_pct) return ACT_PUSH;
        return ACT_POP;
    endfunction

    // Status and pop on a queue that has never held anything.
    task automatic test_empty_queue();
        send_word(ACT_STATUS, 32'sh7FFF_FFFF);
        send_word(ACT_POP, '0);
        wait_drain();
    endtask

    // Extremes in, then out; emptying must clear the descent.
    task automatic test_push_pop_extremes();
        send_word(ACT_PUSH, 32'sh7FFF_FFFF);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_POP, '0);
        send_word(ACT_POP, '0);
        wait_drain();
    endtask

    // Fills across the index wrap with ties and descents, overflows, then clears.
    task automatic test_fill_overflow_clear();
        logic signed [VALUE_W-1:0] fill_vals [16] = '{
            32'sh8000_0000, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd2,
            32'sd1000, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sd5, 32'sd4, 32'sd4, -32'sd7,
            32'sh5555_5555, 32'shAAAA_AAAA};
        foreach (fill_vals[i]) send_word(ACT_PUSH, fill_vals[i]);
        send_word(ACT_PUSH, 32'sh1234_5678);
        send_word(ACT_CLEAR, '0);
        send_word(ACT_STATUS, '0);
        wait_drain();
    endtask

    // Random requests in phases that lean towards filling or draining the queue.
    task automatic test_random_traffic(input int words);
        int bias [4] = '{80, 50, 20, 50};
        int push_pct;
        idle_en  = 1'b1;
        push_pct = bias[0];
        for (int i = 0; i < words; i++) begin
            push_pct = bias[(i / 48) % 4];
            send_word(pick_action(push_pct), random_value());
        end
        wait_drain();
    endtask

    // Back-to-back words with no idling on either side.
    task automatic test_unthrottled_burst(input int words);
        idle_en = 1'b0;
        for (int i = 0; i < words; i++) begin
            send_word(pick_action((i / 32) % 2 == 0 ? 75 : 25), random_value());
        end
        wait_drain();
        idle_en = 1'b1;
    endtask

    // The receiver holds off for a long stretch while words, mostly pushes, keep coming.
    task automatic test_output_hold_off(input int words);
        hold_len = HOLD_OFF_LEN;
        hold_go  = ~hold_go;
        for (int i = 0; i < words; i++) begin
            send_word(pick_action(80), random_value());
        end
        wait_drain();
    endtask

    initial begin
        rd_ptr      = 0;
        wr_ptr      = 0;
        held        = 0;
        descents    = 0;
        last_pushed = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_push_pop_extremes();
        test_fill_overflow_clear();
        test_random_traffic(620);
        test_unthrottled_burst(150);
        test_output_hold_off(60);

        // Let any stray result word show itself before the verdict.
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
